// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of the stack block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stack check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stack check failed");

`endif

// ===== hdl/bsmr_pkg.sv =====
// Package with the types, codes and defaults of the bounded stack block.
package bsmr_pkg;

	localparam int DEFAULT_STACK_DEPTH = 16;
	localparam int WORD_W = 32;

	typedef enum logic [1:0] {
		ACT_PUSH    = 2'd0,
		ACT_POP     = 2'd1,
		ACT_MIDDLE  = 2'd2,
		ACT_REVERSE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_I,
		S_RD_J,
		S_WR_I,
		S_WR_J,
		S_RESP
	} state_t;

endpackage

// ===== hdl/bounded_stack_with_middle_and_reverse.sv =====
// Bounded LIFO stack of signed words with pop, push, middle read and bottom-half reverse.
// Each request transaction yields exactly one response transaction carrying a status,
// a data word (popped or middle entry, otherwise zero) and the entry count after the
// action. Push, pop and middle go from acceptance straight to the response state; reverse
// visits S_RD_I to S_WR_J for each of floor(count / 4) swapped pairs, which needs two reads
// and two writes through the single read and single write port of the entry RAM. A
// finished response waits in its output register while the next request is accepted.
// The entry RAM is never cleared; only entries below the count are ever read.
module bounded_stack_with_middle_and_reverse import bsmr_pkg::*; #(
	parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH,
	localparam int AW = $clog2(STACK_DEPTH),
	localparam int CNT_W = $clog2(STACK_DEPTH + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_ready,
	input  logic [1:0]               action,
	input  logic signed [WORD_W-1:0] push_value,
	output logic                     rsp_valid,
	input  logic                     rsp_ready,
	output logic [1:0]               status,
	output logic signed [WORD_W-1:0] read_value,
	output logic [CNT_W-1:0]         fill_count
);

	state_t state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	status_t pst_q, pst_d;
	logic use_rd_q, use_rd_d;
	logic [AW-1:0] i_q, i_d, j_q, j_d, pairs_q, pairs_d;
	logic [WORD_W-1:0] tmp_q, tmp_d;
	logic rsp_valid_q, rsp_valid_d;
	logic rsp_load;
	status_t status_q;
	logic [WORD_W-1:0] read_value_q;
	logic [CNT_W-1:0] fill_count_q;

	logic we, re;
	logic [AW-1:0] waddr, raddr;
	logic [WORD_W-1:0] wdata, rdata;

	logic [CNT_W-1:0] cm1, half, pairs, mid;
	logic [AW-1:0] i_inc;

	bsmr_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STACK_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign cm1 = count_q - CNT_W'(1);
	assign mid = cm1 >> 1;
	assign half = count_q >> 1;
	assign pairs = count_q >> 2;
	assign i_inc = i_q + AW'(1);

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		pst_d = pst_q;
		use_rd_d = use_rd_q;
		i_d = i_q;
		j_d = j_q;
		pairs_d = pairs_q;
		tmp_d = tmp_q;
		we = 1'b0;
		waddr = i_q;
		wdata = rdata;
		re = 1'b0;
		raddr = i_q;
		rsp_load = 1'b0;
		req_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					pst_d = ST_OK;
					use_rd_d = 1'b0;
					state_d = S_RESP;
					case (action_t'(action))
						ACT_PUSH: begin
							if (count_q == CNT_W'(STACK_DEPTH)) begin
								pst_d = ST_FULL;
							end else begin
								we = 1'b1;
								waddr = count_q[AW-1:0];
								wdata = push_value;
								count_d = count_q + CNT_W'(1);
							end
						end
						ACT_POP: begin
							if (count_q == '0) begin
								pst_d = ST_EMPTY;
							end else begin
								re = 1'b1;
								raddr = cm1[AW-1:0];
								count_d = cm1;
								use_rd_d = 1'b1;
							end
						end
						ACT_MIDDLE: begin
							if (count_q == '0) begin
								pst_d = ST_EMPTY;
							end else begin
								re = 1'b1;
								raddr = mid[AW-1:0];
								use_rd_d = 1'b1;
							end
						end
						ACT_REVERSE: begin
							if (count_q == '0) begin
								pst_d = ST_EMPTY;
							end else begin
								i_d = '0;
								j_d = half[AW-1:0] - AW'(1);
								pairs_d = pairs[AW-1:0];
								if (pairs != '0) begin
									state_d = S_RD_I;
								end
							end
						end
						default: begin
							pst_d = ST_OK;
						end
					endcase
				end
			end
			S_RD_I: begin
				re = 1'b1;
				raddr = i_q;
				state_d = S_RD_J;
			end
			S_RD_J: begin
				tmp_d = rdata;
				re = 1'b1;
				raddr = j_q;
				state_d = S_WR_I;
			end
			S_WR_I: begin
				we = 1'b1;
				waddr = i_q;
				wdata = rdata;
				state_d = S_WR_J;
			end
			S_WR_J: begin
				we = 1'b1;
				waddr = j_q;
				wdata = tmp_q;
				i_d = i_inc;
				j_d = j_q - AW'(1);
				state_d = (i_inc == pairs_q) ? S_RESP : S_RD_I;
			end
			S_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (rsp_load) begin
			rsp_valid_d = 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_d = 1'b0;
		end else begin
			rsp_valid_d = rsp_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		pst_q <= pst_d;
		use_rd_q <= use_rd_d;
		i_q <= i_d;
		j_q <= j_d;
		pairs_q <= pairs_d;
		tmp_q <= tmp_d;
		if (rsp_load) begin
			status_q <= pst_q;
			read_value_q <= use_rd_q ? rdata : '0;
			fill_count_q <= count_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status = status_q;
	assign read_value = read_value_q;
	assign fill_count = fill_count_q;

endmodule

// ===== hdl/bsmr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module bsmr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/bsmr_checker.sv =====
// Port-level checker for the bounded stack block and its bind statement.
`include "assert_macros.svh"

module bsmr_checker import bsmr_pkg::*; #(
	parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH,
	localparam int CNT_W = $clog2(STACK_DEPTH + 1)
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     req_valid,
	input logic                     req_ready,
	input logic                     rsp_valid,
	input logic                     rsp_ready,
	input logic [1:0]               status,
	input logic signed [WORD_W-1:0] read_value,
	input logic [CNT_W-1:0]         fill_count
);

	`ASSERT_SAME(a_count_bound, rsp_valid, fill_count <= CNT_W'(STACK_DEPTH))
	`ASSERT_SAME(a_full_status, rsp_valid && status == ST_FULL,
		fill_count == CNT_W'(STACK_DEPTH) && read_value == '0)
	`ASSERT_SAME(a_empty_status, rsp_valid && status == ST_EMPTY,
		fill_count == '0 && read_value == '0)
	`ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)
	`ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
		rsp_valid && $stable(status) && $stable(read_value) && $stable(fill_count))

endmodule

bind bounded_stack_with_middle_and_reverse bsmr_checker #(
	.STACK_DEPTH(STACK_DEPTH)
) u_bsmr_checker (.*);

// ===== bench/bounded_stack_with_middle_and_reverse_tb.sv =====
// Self-checking testbench for the bounded stack with directed, random and backpressure tests.
module bounded_stack_with_middle_and_reverse_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bsmr_pkg::*;

	localparam int DEPTH = DEFAULT_STACK_DEPTH;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 40;

	typedef struct packed {
		status_t                  st;
		logic signed [WORD_W-1:0] word;
		logic [CNT_W-1:0]         count;
	} stack_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     req_valid;
	logic                     req_ready;
	logic [1:0]               action;
	logic signed [WORD_W-1:0] push_value;
	logic                     rsp_valid;
	logic                     rsp_ready;
	logic [1:0]               status;
	logic signed [WORD_W-1:0] read_value;
	logic [CNT_W-1:0]         fill_count;

	logic signed [WORD_W-1:0] stack_words [DEPTH];
	int                       stack_fill;
	stack_result_t            pending_results [$];
	int                       err_count;
	int                       req_idle_pct;
	int                       rsp_idle_pct;
	bit                       hold_request;

	bounded_stack_with_middle_and_reverse #(
		.STACK_DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.action(action),
		.push_value(push_value),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status(status),
		.read_value(read_value),
		.fill_count(fill_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic stack_result_t predict_stack_action(action_t act,
			logic signed [WORD_W-1:0] val);
		stack_result_t            r;
		int                       half;
		logic signed [WORD_W-1:0] tmp;
		r.st = ST_OK;
		r.word = '0;
		case (act)
			ACT_PUSH: begin
				if (stack_fill >= DEPTH) begin
					r.st = ST_FULL;
				end else begin
					stack_words[stack_fill] = val;
					stack_fill++;
				end
			end
			ACT_POP: begin
				if (stack_fill == 0) begin
					r.st = ST_EMPTY;
				end else begin
					stack_fill--;
					r.word = stack_words[stack_fill];
				end
			end
			ACT_MIDDLE: begin
				if (stack_fill == 0) begin
					r.st = ST_EMPTY;
				end else begin
					r.word = stack_words[(stack_fill - 1) / 2];
				end
			end
			ACT_REVERSE: begin
				if (stack_fill == 0) begin
					r.st = ST_EMPTY;
				end else begin
					half = stack_fill / 2;
					for (int i = 0; i < half / 2; i++) begin
						tmp = stack_words[i];
						stack_words[i] = stack_words[half - 1 - i];
						stack_words[half - 1 - i] = tmp;
					end
				end
			end
		endcase
		r.count = CNT_W'(stack_fill);
		return r;
	endfunction

	task automatic report_error(string msg);
		$display("%0t: %s", $time, msg);
		err_count++;
	endtask

	task automatic send_item(action_t act, logic signed [WORD_W-1:0] val);
		@(negedge clk);
		if ($urandom_range(99) < req_idle_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		req_valid <= 1'b1;
		action <= act;
		push_value <= val;
		do
			@(posedge clk);
		while (!req_ready);
		pending_results.push_back(predict_stack_action(act, val));
	endtask

	function automatic logic signed [WORD_W-1:0] pick_word();
		case ($urandom_range(7))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_empty_refusals();
		send_item(ACT_POP, $urandom);
		send_item(ACT_MIDDLE, $urandom);
		send_item(ACT_REVERSE, $urandom);
	endtask

	task automatic test_single_entry();
		send_item(ACT_PUSH, 32'sh8000_0000);
		send_item(ACT_REVERSE, $urandom);
		send_item(ACT_MIDDLE, $urandom);
	endtask

	task automatic test_fill_to_full();
		send_item(ACT_PUSH, 32'sh7fff_ffff);
		send_item(ACT_PUSH, '1);
		send_item(ACT_PUSH, '0);
		send_item(ACT_PUSH, 32'sd1);
		send_item(ACT_PUSH, 32'sh5555_5555);
		send_item(ACT_PUSH, 32'shaaaa_aaaa);
		repeat (DEPTH - 7) send_item(ACT_PUSH, $urandom);
		send_item(ACT_PUSH, $urandom);
		send_item(ACT_MIDDLE, $urandom);
		send_item(ACT_REVERSE, $urandom);
		send_item(ACT_POP, $urandom);
	endtask

	// The push bias is redrawn every 32 transactions so the stack swings between full and empty.
	task automatic test_random_mix(int n_items);
		int push_bias;
		int r;
		push_bias = 50;
		for (int n = 0; n < n_items; n++) begin
			if (n % 32 == 0) begin
				case ($urandom_range(2))
					0: push_bias = 20;
					1: push_bias = 50;
					default: push_bias = 85;
				endcase
			end
			r = $urandom_range(99);
			if (r < 15) begin
				send_item(ACT_MIDDLE, $urandom);
			end else if (r < 30) begin
				send_item(ACT_REVERSE, $urandom);
			end else if ($urandom_range(99) < push_bias) begin
				send_item(ACT_PUSH, pick_word());
			end else begin
				send_item(ACT_POP, $urandom);
			end
		end
	endtask

	task automatic test_backpressure();
		hold_request = 1'b1;
		test_random_mix(40);
	endtask

	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
		end
	end

	always @(posedge clk) begin
		stack_result_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_results.size() == 0) begin
				report_error($sformatf("response with none expected: status %0d data 0x%08h count %0d",
					status, read_value, fill_count));
			end else begin
				want = pending_results.pop_front();
				if (status !== want.st)
					report_error($sformatf("status: got %0d, expected %0d", status, want.st));
				if (read_value !== want.word)
					report_error($sformatf("read_value: got 0x%08h, expected 0x%08h",
						read_value, want.word));
				if (fill_count !== want.count)
					report_error($sformatf("fill_count: got %0d, expected %0d",
						fill_count, want.count));
			end
		end
	end

	initial begin
		int stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
				stalled = 0;
			else
				stalled++;
		end
		$display("bounded_stack_with_middle_and_reverse_tb: done, errors");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		action = ACT_PUSH;
		push_value = '0;
		hold_request = 1'b0;
		err_count = 0;
		stack_fill = 0;
		req_idle_pct = 20;
		rsp_idle_pct = 78;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		test_empty_refusals();
		test_single_entry();
		test_fill_to_full();
		test_random_mix(490);
		req_idle_pct = 78;
		rsp_idle_pct = 20;
		test_random_mix(490);
		req_idle_pct = 0;
		rsp_idle_pct = 0;
		test_random_mix(490);
		test_backpressure();

		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("bounded_stack_with_middle_and_reverse_tb: done, clean");
		else
			$display("bounded_stack_with_middle_and_reverse_tb: done, errors");
		$finish;
	end

endmodule
